// ----- rtl/vmn_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the vector and matrix norm engine.
// No dependencies; every other file of the block imports this package.
package vmn_pkg;

  // Element and accumulator widths.
  localparam int ELEMENT_WIDTH   = 16;
  localparam int MAG_W           = ELEMENT_WIDTH;
  localparam int SQ_W            = 2 * MAG_W;
  localparam int TOTAL_W         = 48;
  localparam int WORD_W          = 32;
  localparam int MAX_COLUMNS_DEF = 1024;

  // Configuration port.
  localparam int MODE_W      = 3;
  localparam int COUNT_W     = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] CFG_NORM_MODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

  localparam logic [MODE_W-1:0] NORM_MODE_RESET    = 3'd1;
  localparam logic [COUNT_W-1:0] COLUMN_COUNT_RESET = 11'd1;

  // Decoded norm selection.
  typedef enum logic [2:0] {
    MODE_L1     = 3'd0,
    MODE_L2     = 3'd1,
    MODE_MAX    = 3'd2,
    MODE_COLSUM = 3'd3,
    MODE_ROWSUM = 3'd4
  } mode_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_APPLY,
    ST_KICK,
    ST_ROOT,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Input and result words.
  typedef struct packed {
    logic signed [ELEMENT_WIDTH-1:0] element_value;
    logic                            last_element;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] norm_value;
    logic              overflowed;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic square;
    logic apply;
    logic root_start;
    logic scan;
    logic emit;
    logic cfg_write;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mode_t mode;
    logic  last;
    logic  scan_end;
    logic  root_done;
  } dp_status_t;

  // Unused mode codes fall back to L2.
  function automatic mode_t decode_mode(input logic [MODE_W-1:0] code);
    mode_t m;
    case (code)
      3'd0:    m = MODE_L1;
      3'd2:    m = MODE_MAX;
      3'd3:    m = MODE_COLSUM;
      3'd4:    m = MODE_ROWSUM;
      default: m = MODE_L2;
    endcase
    return m;
  endfunction

  // Magnitude of a two's complement element; the most negative value maps correctly.
  function automatic logic [MAG_W-1:0] magnitude(input logic signed [ELEMENT_WIDTH-1:0] v);
    logic [MAG_W-1:0] m;
    if (v[ELEMENT_WIDTH-1]) begin
      m = MAG_W'(~v) + MAG_W'(1);
    end else begin
      m = MAG_W'(v);
    end
    return m;
  endfunction

endpackage

// ----- rtl/vmn_isqrt.sv -----
`timescale 1ns / 1ps
// Iterative integer square root, two radicand bits per cycle.
// Depends on vmn_pkg for the default radicand width.
module vmn_isqrt import vmn_pkg::*; #(
  parameter int RAD_W = TOTAL_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [RAD_W-1:0]   radicand,
  output logic               done,
  output logic [RAD_W/2-1:0] root
);

  localparam int ITER  = RAD_W / 2;
  localparam int RW    = ITER + 2;
  localparam int CNT_W = (ITER > 1) ? $clog2(ITER) : 1;

  logic              active_r, active_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [RW-1:0]     rem_r, rem_nxt;
  logic [ITER-1:0]   root_r, root_nxt;
  logic [RW-1:0]     rem_sh;
  logic [RW-1:0]     trial;

  // One restoring step: bring down two bits and try to set the next root bit.
  always_comb begin
    rem_sh     = {rem_r[RW-3:0], rad_r[RAD_W-1 -: 2]};
    trial      = {root_r, 2'b01};
    active_nxt = active_r;
    done_nxt   = 1'b0;
    count_nxt  = count_r;
    rad_nxt    = rad_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    if (start) begin
      active_nxt = 1'b1;
      count_nxt  = '0;
      rad_nxt    = radicand;
      rem_nxt    = '0;
      root_nxt   = '0;
    end else if (active_r) begin
      rad_nxt   = {rad_r[RAD_W-3:0], 2'b00};
      count_nxt = count_r + CNT_W'(1);
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ITER-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ITER-2:0], 1'b0};
      end
      if (count_r == CNT_W'(ITER - 1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  // Control flops reset; the working values do not need to.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      count_r  <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      count_r  <= count_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- rtl/vmn_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: configuration registers, accumulators, column store, square root and result word.
// Depends on vmn_pkg and vmn_isqrt; driven by commands from vmn_ctrl.
module vmn_datapath import vmn_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             status,
  input  in_word_t               in_data,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_valid,
  output out_word_t              out_data
);

  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [WORD_W-1:0]  WORD_MAX  = '1;

  // Configuration.
  logic [MODE_W-1:0]  norm_mode_r, norm_mode_nxt;
  logic [COUNT_W-1:0] column_count_r, column_count_nxt;
  mode_t              mode;
  logic [31:0]        cols_wide;
  logic [CNT_W-1:0]   cols_eff;

  // Element pipeline.
  in_word_t           elem_r, elem_nxt;
  logic [MAG_W-1:0]   mag_r, mag_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;

  // Set state.
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [WORD_W-1:0]  peak_r, peak_nxt;
  logic [WORD_W-1:0]  row_r, row_nxt;
  logic [CW-1:0]      col_pos_r, col_pos_nxt;
  logic               first_row_r, first_row_nxt;
  logic               sat_r, sat_nxt;

  // Column scan.
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [CNT_W-1:0]   scan_limit_r, scan_limit_nxt;
  logic               scan_pend_r, scan_pend_nxt;

  // Column store.
  logic [WORD_W-1:0]  col_mem [MAX_COLUMNS];
  logic [WORD_W-1:0]  rd_data_r;
  logic [CW-1:0]      rd_addr;
  logic               mem_we;
  logic [WORD_W-1:0]  mem_wdata;

  // Result word.
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r, out_data_nxt;

  // Arithmetic helpers.
  logic [TOTAL_W:0]   tot_sum;
  logic [WORD_W:0]    col_sum;
  logic [WORD_W:0]    row_sum;
  logic [WORD_W-1:0]  row_val;
  logic [CNT_W-1:0]   pos_inc;
  logic               wrap;
  logic               cfg_hit;
  logic               clear_set;
  logic               l1_over;
  logic [TOTAL_W/2-1:0] root;
  logic               root_done;

  // Mode decode and the clamped column count.
  always_comb begin
    mode = decode_mode(norm_mode_r);
    if (column_count_r == '0) begin
      cols_wide = 32'd1;
    end else if (32'(column_count_r) > 32'(MAX_COLUMNS)) begin
      cols_wide = 32'(MAX_COLUMNS);
    end else begin
      cols_wide = 32'(column_count_r);
    end
    cols_eff = cols_wide[CNT_W-1:0];
  end

  // Saturating sums and the column position step.
  always_comb begin
    if (mode == MODE_L2) begin
      tot_sum = {1'b0, total_r} + (TOTAL_W+1)'(sq_r);
    end else begin
      tot_sum = {1'b0, total_r} + (TOTAL_W+1)'(mag_r);
    end
    col_sum = {1'b0, rd_data_r} + (WORD_W+1)'(mag_r);
    row_sum = {1'b0, row_r} + (WORD_W+1)'(mag_r);
    row_val = row_sum[WORD_W] ? WORD_MAX : row_sum[WORD_W-1:0];
    pos_inc = CNT_W'(col_pos_r) + CNT_W'(1);
    wrap    = pos_inc >= cols_eff;
    l1_over = |total_r[TOTAL_W-1:WORD_W];
    cfg_hit = cmd.cfg_write &&
              (cfg_index == CFG_NORM_MODE || cfg_index == CFG_COLUMN_COUNT);
    clear_set = cmd.emit || cfg_hit;
  end

  // Next-state logic for the whole datapath.
  always_comb begin
    norm_mode_nxt    = norm_mode_r;
    column_count_nxt = column_count_r;
    elem_nxt         = elem_r;
    mag_nxt          = mag_r;
    sq_nxt           = sq_r;
    total_nxt        = total_r;
    peak_nxt         = peak_r;
    row_nxt          = row_r;
    col_pos_nxt      = col_pos_r;
    first_row_nxt    = first_row_r;
    sat_nxt          = sat_r;
    scan_idx_nxt     = scan_idx_r;
    scan_limit_nxt   = scan_limit_r;
    scan_pend_nxt    = scan_pend_r;
    rd_addr          = col_pos_r;
    mem_we           = 1'b0;
    mem_wdata        = col_sum[WORD_W-1:0];
    out_valid_nxt    = 1'b0;
    out_data_nxt     = out_data_r;

    // Take in the accepted word.
    if (cmd.capture) begin
      elem_nxt = in_data;
    end

    // Magnitude and square, registered before accumulation.
    if (cmd.square) begin
      mag_nxt = magnitude(elem_r.element_value);
      sq_nxt  = SQ_W'(mag_nxt) * SQ_W'(mag_nxt);
    end

    // Fold one element into the set state.
    if (cmd.apply) begin
      case (mode)
        MODE_L1, MODE_L2: begin
          if (tot_sum[TOTAL_W]) begin
            total_nxt = TOTAL_MAX;
            sat_nxt   = 1'b1;
          end else begin
            total_nxt = tot_sum[TOTAL_W-1:0];
          end
        end
        MODE_MAX: begin
          if (WORD_W'(mag_r) > peak_r) begin
            peak_nxt = WORD_W'(mag_r);
          end
        end
        MODE_COLSUM: begin
          mem_we = 1'b1;
          if (first_row_r) begin
            mem_wdata = WORD_W'(mag_r);
          end else if (col_sum[WORD_W]) begin
            mem_wdata = WORD_MAX;
            sat_nxt   = 1'b1;
          end
          if (wrap) begin
            col_pos_nxt   = '0;
            first_row_nxt = 1'b0;
          end else begin
            col_pos_nxt = pos_inc[CW-1:0];
          end
        end
        MODE_ROWSUM: begin
          row_nxt = row_val;
          if (row_sum[WORD_W]) begin
            sat_nxt = 1'b1;
          end
          col_pos_nxt = wrap ? '0 : pos_inc[CW-1:0];
          if (wrap || elem_r.last_element) begin
            if (row_val > peak_r) begin
              peak_nxt = row_val;
            end
            row_nxt = '0;
          end
        end
        default: begin
        end
      endcase
      // A finished first row opens every column to the scan.
      scan_idx_nxt   = '0;
      scan_pend_nxt  = 1'b0;
      scan_limit_nxt = first_row_nxt ? CNT_W'(col_pos_nxt) : cols_eff;
    end

    // Column scan: one store read issued per cycle, compared in the cycle after.
    if (cmd.scan) begin
      if (scan_pend_r && rd_data_r > peak_r) begin
        peak_nxt = rd_data_r;
      end
      if (scan_idx_r < scan_limit_r) begin
        rd_addr       = scan_idx_r[CW-1:0];
        scan_idx_nxt  = scan_idx_r + CNT_W'(1);
        scan_pend_nxt = 1'b1;
      end else begin
        scan_pend_nxt = 1'b0;
      end
    end

    // Form the result word.
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt.overflowed = sat_r;
      case (mode)
        MODE_L1: begin
          if (l1_over) begin
            out_data_nxt.norm_value = WORD_MAX;
            out_data_nxt.overflowed = 1'b1;
          end else begin
            out_data_nxt.norm_value = total_r[WORD_W-1:0];
          end
        end
        MODE_L2: out_data_nxt.norm_value = WORD_W'(root);
        default: out_data_nxt.norm_value = peak_r;
      endcase
    end

    // Register writes.
    if (cmd.cfg_write) begin
      case (cfg_index)
        CFG_NORM_MODE:    norm_mode_nxt    = cfg_data[MODE_W-1:0];
        CFG_COLUMN_COUNT: column_count_nxt = cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end

    // Return the set state to its starting values.
    if (clear_set) begin
      total_nxt     = '0;
      peak_nxt      = '0;
      row_nxt       = '0;
      col_pos_nxt   = '0;
      first_row_nxt = 1'b1;
      sat_nxt       = 1'b0;
    end
  end

  // Control and set state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_mode_r    <= NORM_MODE_RESET;
      column_count_r <= COLUMN_COUNT_RESET;
      total_r        <= '0;
      peak_r         <= '0;
      row_r          <= '0;
      col_pos_r      <= '0;
      first_row_r    <= 1'b1;
      sat_r          <= 1'b0;
      scan_idx_r     <= '0;
      scan_limit_r   <= '0;
      scan_pend_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      norm_mode_r    <= norm_mode_nxt;
      column_count_r <= column_count_nxt;
      total_r        <= total_nxt;
      peak_r         <= peak_nxt;
      row_r          <= row_nxt;
      col_pos_r      <= col_pos_nxt;
      first_row_r    <= first_row_nxt;
      sat_r          <= sat_nxt;
      scan_idx_r     <= scan_idx_nxt;
      scan_limit_r   <= scan_limit_nxt;
      scan_pend_r    <= scan_pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    elem_r     <= elem_nxt;
    mag_r      <= mag_nxt;
    sq_r       <= sq_nxt;
    out_data_r <= out_data_nxt;
  end

  // Column store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      col_mem[col_pos_r] <= mem_wdata;
    end
    rd_data_r <= col_mem[rd_addr];
  end

  // Square root of the sum of squares.
  vmn_isqrt #(
    .RAD_W(TOTAL_W)
  ) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.root_start),
    .radicand(total_r),
    .done    (root_done),
    .root    (root)
  );

  // Status back to the controller.
  always_comb begin
    status.mode      = mode;
    status.last      = elem_r.last_element;
    status.scan_end  = scan_idx_r >= scan_limit_r;
    status.root_done = root_done;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The column position always points inside the row.
  a_pos_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(col_pos_r) < cols_eff)
    else $error("column position outside the row");

  // Results never come in consecutive cycles.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  // The scan never runs past its limit.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_idx_r <= scan_limit_r)
    else $error("column scan past its limit");

endmodule

// ----- rtl/vmn_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: sequences each word through the datapath and closes a set.
// Depends on vmn_pkg for the state, command and status types.
module vmn_ctrl import vmn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       cfg_valid,
  input  dp_status_t status,
  output logic       busy,
  output logic       cfg_ready,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   idle;
  logic   accept;

  assign idle   = state_r == ST_IDLE;
  assign accept = start && idle;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_APPLY;
      ST_APPLY: begin
        if (!status.last) begin
          state_nxt = ST_IDLE;
        end else begin
          case (status.mode)
            MODE_COLSUM: state_nxt = ST_SCAN;
            MODE_L2:     state_nxt = ST_KICK;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_KICK:  state_nxt = ST_ROOT;
      ST_ROOT:  if (status.root_done) state_nxt = ST_DONE;
      ST_SCAN:  if (status.scan_end) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd            = '0;
    cmd.capture    = accept;
    cmd.square     = state_r == ST_LOAD;
    cmd.apply      = state_r == ST_APPLY;
    cmd.root_start = state_r == ST_KICK;
    cmd.scan       = state_r == ST_SCAN;
    cmd.emit       = state_r == ST_DONE;
    cmd.cfg_write  = cfg_valid && idle;
    busy           = !idle;
    cfg_ready      = idle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // An accepted word always goes to the load step.
  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_LOAD)
    else $error("accepted word did not reach the load step");

  // After a result the controller is free again.
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> state_r == ST_IDLE)
    else $error("controller not idle after a result");

  // The square root only runs for the L2 norm.
  a_root_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KICK || state_r == ST_ROOT) |-> status.mode == MODE_L2)
    else $error("square root started outside L2 mode");

  // The column scan only runs for the matrix 1-norm.
  a_scan_mode: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> status.mode == MODE_COLSUM)
    else $error("column scan outside column-sum mode");

endmodule

// ----- rtl/vector_matrix_norm_engine.sv -----
`timescale 1ns / 1ps
// Top level of the vector and matrix norm engine: controller plus datapath.
// Depends on vmn_pkg, vmn_ctrl, vmn_datapath and vmn_isqrt.
//
// A word is taken when start is high and busy is low. Each element occupies the
// engine through accept, a magnitude and square stage, and an update of the set
// state, in column-sum mode a read-modify-write of the column store. The word
// that carries last_element then closes the set: L1, max-magnitude and row-sum
// modes go straight to the result, the L2 mode first runs the iterative square
// root (two radicand bits per cycle), and the column-sum mode first scans the
// written columns through the store's one read port. The result is held on
// out_data for exactly one cycle with out_valid high and cannot be stalled; a new
// word may be accepted in that same cycle. The column store is not cleared after
// reset; only the entries written in the current set are read. Configuration writes
// are taken while busy is low; those to a defined index abandon any set in progress.
module vector_matrix_norm_engine import vmn_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  in_word_t               in_data,
  output logic                   out_valid,
  output out_word_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencing.
  vmn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cfg_valid(cfg_valid),
    .status   (status),
    .busy     (busy),
    .cfg_ready(cfg_ready),
    .cmd      (cmd)
  );

  // Arithmetic, storage and result word.
  vmn_datapath #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_data  (in_data),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for vector_matrix_norm_engine: a directed table, then random norm sets.
// Depends on vmn_pkg and the engine RTL; results are checked by a predictor or typed norms.
module tb import vmn_pkg::*; ();

  localparam int SETTLE_CYCLES = 40;
  localparam int PRINT_LIMIT = 50;
  localparam int RANDOM_ITEMS = 1200;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  localparam longint unsigned TOTAL_MAX = 64'h0000_FFFF_FFFF_FFFF;
  localparam longint unsigned WORD_MAX = 64'h0000_0000_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_data = '0;
  logic out_valid;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  vector_matrix_norm_engine dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor copy of the registers and the per-set state.
  logic [MODE_W-1:0] mode_reg;
  logic [COUNT_W-1:0] count_reg;
  logic [TOTAL_W-1:0] sum_acc;
  logic [WORD_W-1:0] peak_acc;
  logic [WORD_W-1:0] row_acc;
  int unsigned col_pos;
  bit first_row;
  bit sat_seen;
  logic [WORD_W-1:0] col_sums [MAX_COLUMNS_DEF];

  out_word_t norm_q[$];
  out_word_t oldest_norm;
  int err_count = 0;
  int unsigned words_sent = 0;
  bit quiet = 1'b0;

  // Directed stimulus table.
  typedef enum logic [1:0] {ROW_WRITE, ROW_WORD} row_kind_t;
  typedef struct {
    row_kind_t kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
    in_word_t word;
    bit typed;
    out_word_t result;
  } plan_row_t;
  plan_row_t plan[$];

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    err_count++;
    if (err_count <= PRINT_LIMIT) begin
      $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  // Results cannot be held off, so every strobe is compared on the spot.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (norm_q.size() == 0) begin
        report_mismatch("norm with nothing pending", out_data.norm_value, 0);
      end else begin
        oldest_norm = norm_q.pop_front();
        if (out_data.norm_value !== oldest_norm.norm_value) begin
          report_mismatch("norm_value", out_data.norm_value, oldest_norm.norm_value);
        end
        if (out_data.overflowed !== oldest_norm.overflowed) begin
          report_mismatch("overflowed", out_data.overflowed, oldest_norm.overflowed);
        end
      end
    end
  end

  function automatic longint unsigned sat_add(input longint unsigned a, input longint unsigned b,
                                              input longint unsigned lim);
    longint unsigned s;
    s = a + b;
    if (s > lim) begin
      sat_seen = 1'b1;
      s = lim;
    end
    return s;
  endfunction

  // Floor square root, built one result bit at a time from the top.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int b = 23; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  function automatic int unsigned columns_used(input logic [COUNT_W-1:0] count);
    if (count == 0) return 1;
    if (count > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
    return count;
  endfunction

  function automatic void clear_norm_set();
    sum_acc = '0;
    peak_acc = '0;
    row_acc = '0;
    col_pos = 0;
    first_row = 1'b1;
    sat_seen = 1'b0;
  endfunction

  // Only the two defined register indexes change anything.
  function automatic void note_write(input logic [CFG_INDEX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_NORM_MODE) begin
      mode_reg = data[MODE_W-1:0];
      clear_norm_set();
    end else if (idx == CFG_COLUMN_COUNT) begin
      count_reg = data;
      clear_norm_set();
    end
  endfunction

  // Advances the predictor by one word; returns 1 with the norm when the set closes.
  function automatic bit predict_norm(input in_word_t w, output out_word_t r);
    int v;
    longint unsigned mag;
    longint unsigned res;
    int unsigned cols;
    int unsigned span;
    v = $signed(w.element_value);
    mag = (v < 0) ? longint'(-v) : longint'(v);
    cols = columns_used(count_reg);
    if (col_pos >= cols) col_pos = 0;
    case (mode_reg)
      MODE_L1: sum_acc = TOTAL_W'(sat_add(sum_acc, mag, TOTAL_MAX));
      MODE_MAX: if (mag > peak_acc) peak_acc = WORD_W'(mag);
      MODE_COLSUM: begin
        if (first_row) col_sums[col_pos] = WORD_W'(mag);
        else col_sums[col_pos] = WORD_W'(sat_add(col_sums[col_pos], mag, WORD_MAX));
        col_pos++;
        if (col_pos >= cols) begin
          col_pos = 0;
          first_row = 1'b0;
        end
      end
      MODE_ROWSUM: begin
        row_acc = WORD_W'(sat_add(row_acc, mag, WORD_MAX));
        col_pos++;
        // A row closes at its last column or when the set ends mid-row.
        if (col_pos >= cols || w.last_element) begin
          if (row_acc > peak_acc) peak_acc = row_acc;
          row_acc = '0;
          if (col_pos >= cols) col_pos = 0;
        end
      end
      default: sum_acc = TOTAL_W'(sat_add(sum_acc, mag * mag, TOTAL_MAX));
    endcase
    if (!w.last_element) return 1'b0;
    case (mode_reg)
      MODE_L1: res = sum_acc;
      MODE_MAX, MODE_ROWSUM: res = peak_acc;
      MODE_COLSUM: begin
        // Still on the first row: only the columns written so far count.
        span = first_row ? col_pos : cols;
        res = 0;
        for (int i = 0; i < span; i++) begin
          if (col_sums[i] > res) res = col_sums[i];
        end
      end
      default: res = floor_root(sum_acc);
    endcase
    if (res > WORD_MAX) begin
      res = WORD_MAX;
      sat_seen = 1'b1;
    end
    r.norm_value = WORD_W'(res);
    r.overflowed = sat_seen;
    clear_norm_set();
    return 1'b1;
  endfunction

  function automatic in_word_t noise_word();
    in_word_t w;
    w.element_value = ELEMENT_WIDTH'($urandom);
    w.last_element = 1'($urandom);
    return w;
  endfunction

  // Mix of extremes, small values and full-range values.
  function automatic logic signed [ELEMENT_WIDTH-1:0] rand_element();
    int s;
    s = int'($urandom_range(0, 31)) - 16;
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return '1;
      4, 5: return ELEMENT_WIDTH'(s);
      default: return ELEMENT_WIDTH'($urandom);
    endcase
  endfunction

  // Set length: matrix modes mostly get whole rows, but at full store width mostly short sets.
  function automatic int unsigned pick_len(input logic [MODE_W-1:0] m, input int unsigned eff);
    if (m == MODE_COLSUM || m == MODE_ROWSUM) begin
      if (eff >= MAX_COLUMNS_DEF) begin
        if ($urandom_range(0, 7) == 0) return eff + $urandom_range(0, 4);
        return $urandom_range(1, 12);
      end
      if ($urandom_range(0, 3) != 0) return eff * $urandom_range(1, 4);
      return $urandom_range(1, 2 * eff + 1);
    end
    if ($urandom_range(0, 4) == 0) return $urandom_range(20, 100);
    return $urandom_range(1, 20);
  endfunction

  function automatic void plan_write(input logic [CFG_INDEX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '{kind: ROW_WRITE, index: idx, data: data, word: '0, typed: 1'b0, result: '0};
    plan.push_back(row);
  endfunction

  function automatic void plan_word(input logic signed [ELEMENT_WIDTH-1:0] e);
    plan_row_t row;
    row = '{kind: ROW_WORD, index: '0, data: '0, word: '{e, 1'b0}, typed: 1'b0, result: '0};
    plan.push_back(row);
  endfunction

  // Closing word of a set with its norm typed in; no saturation in these.
  function automatic void plan_check(input logic signed [ELEMENT_WIDTH-1:0] e,
                                     input logic [WORD_W-1:0] norm);
    plan_row_t row;
    row = '{kind: ROW_WORD, index: '0, data: '0, word: '{e, 1'b1}, typed: 1'b1,
            result: '{norm, 1'b0}};
    plan.push_back(row);
  endfunction

  // One input word; start stays high between back-to-back words.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    out_word_t r;
    if (!quiet && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      in_data <= noise_word();
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(5, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    if (predict_norm(w, r)) norm_q.push_back(typed ? typed_res : r);
  endtask

  task automatic send_set(input int unsigned len, input bit closed);
    in_word_t w;
    for (int unsigned n = 1; n <= len; n++) begin
      w.element_value = rand_element();
      w.last_element = closed && (n == len);
      send_word(w, 1'b0, '0);
    end
  endtask

  // Stop sending and let the engine drain before a register write.
  task automatic settle();
    start <= 1'b0;
    in_data <= noise_word();
    while (norm_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_valid stays high for back-to-back writes; the caller lowers it.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    note_write(idx, data);
  endtask

  initial begin
    int unsigned base;
    int unsigned done;
    int unsigned eff;
    int unsigned nsets;
    int phase;
    logic [MODE_W-1:0] mode_pick;
    logic [COUNT_W-1:0] count_pick;
    int r;

    for (int i = 0; i < MAX_COLUMNS_DEF; i++) col_sums[i] = '0;
    mode_reg = NORM_MODE_RESET;
    count_reg = COLUMN_COUNT_RESET;
    clear_norm_set();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset mode is L2 with one column.
    plan_check(3, 3);
    plan_check(-32768, 32768);
    plan_write(CFG_NORM_MODE, CFG_DATA_W'(MODE_L1));
    plan_word(32767);
    plan_check(-32768, 65535);
    // Upper data bits are ignored by the mode register.
    plan_write(CFG_NORM_MODE, {8'hFF, MODE_MAX});
    plan_word(32767);
    plan_check(-32768, 32768);
    // Unused mode codes behave as L2.
    plan_write(CFG_NORM_MODE, {8'hFF, MODE_UNUSED});
    plan_word(3);
    plan_check(-4, 5);
    // A column count of zero acts as one.
    plan_write(CFG_NORM_MODE, CFG_DATA_W'(MODE_ROWSUM));
    plan_write(CFG_COLUMN_COUNT, '0);
    plan_word(5);
    plan_word(-7);
    plan_check(2, 7);
    // Count above the store size clamps; set ends inside the first row.
    plan_write(CFG_NORM_MODE, CFG_DATA_W'(MODE_COLSUM));
    plan_write(CFG_COLUMN_COUNT, '1);
    plan_word(10);
    plan_check(-20, 20);
    // Partial second row in column-sum mode.
    plan_write(CFG_COLUMN_COUNT, 11'd3);
    plan_word(1);
    plan_word(2);
    plan_word(3);
    plan_check(4, 5);
    // Partial last row counts as a row.
    plan_write(CFG_NORM_MODE, CFG_DATA_W'(MODE_ROWSUM));
    plan_word(1);
    plan_word(2);
    plan_word(3);
    plan_word(-4);
    plan_check(-5, 9);
    // A write to an undefined index changes nothing.
    plan_write(CFG_SPARE, '1);
    plan_check(6, 6);
    // A register write abandons the set in progress.
    plan_write(CFG_NORM_MODE, CFG_DATA_W'(MODE_L1));
    plan_word(100);
    plan_word(200);
    plan_write(CFG_COLUMN_COUNT, 11'd1);
    plan_check(7, 7);

    for (int k = 0; k < plan.size(); k++) begin
      if (plan[k].kind == ROW_WRITE) begin
        if (k == 0 || plan[k-1].kind != ROW_WRITE) settle();
        write_reg(plan[k].index, plan[k].data);
      end else begin
        if (k > 0 && plan[k-1].kind == ROW_WRITE) cfg_valid <= 1'b0;
        send_word(plan[k].word, plan[k].typed, plan[k].result);
      end
    end

    // Random phases: new settings, then several sets under them.
    base = words_sent;
    phase = 0;
    while (words_sent - base < RANDOM_ITEMS) begin
      r = $urandom_range(0, 11);
      mode_pick = (r < 10) ? MODE_W'(r % 5) : MODE_W'(5 + $urandom_range(0, 2));
      r = $urandom_range(0, 19);
      if (r == 0) count_pick = '0;
      else if (r == 1) count_pick = COUNT_W'(MAX_COLUMNS_DEF);
      else if (r == 2) count_pick = COUNT_W'($urandom_range(MAX_COLUMNS_DEF + 1, 2047));
      else if (r < 6) count_pick = COUNT_W'($urandom_range(9, 40));
      else count_pick = COUNT_W'($urandom_range(1, 8));
      settle();
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_NORM_MODE, {8'($urandom), mode_pick});
        write_reg(CFG_COLUMN_COUNT, count_pick);
      end else begin
        write_reg(CFG_COLUMN_COUNT, count_pick);
        write_reg(CFG_NORM_MODE, {8'($urandom), mode_pick});
      end
      if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
      cfg_valid <= 1'b0;
      eff = columns_used(count_pick);
      nsets = $urandom_range(2, 6);
      for (int s = 0; s < nsets; s++) begin
        done = words_sent - base;
        if (done >= RANDOM_ITEMS) break;
        quiet = (done >= 400 && done < 700);
        // Once, hold the next word back until every pending norm is out.
        if (phase == 2 && s == 1) begin
          start <= 1'b0;
          @(posedge clk);
          while (norm_q.size() != 0) @(posedge clk);
        end
        send_set(pick_len(mode_pick, eff), 1'b1);
      end
      // Sometimes leave a set open so the next write abandons it.
      if ($urandom_range(0, 9) == 0) send_set($urandom_range(1, 5), 1'b0);
      phase++;
    end

    start <= 1'b0;
    while (norm_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- vector_matrix_norm_engine.f -----
rtl/vmn_pkg.sv
rtl/vmn_isqrt.sv
rtl/vmn_datapath.sv
rtl/vmn_ctrl.sv
rtl/vector_matrix_norm_engine.sv
bench/tb.sv
